### hw/rtl/swmd_pkg.sv
// Shared types, widths and register codes for the sliding window motion detector.
// No dependencies; imported by every module of the block.
package swmd_pkg;

  localparam int unsigned WINDOW_LENGTH = 100;

  localparam int unsigned ANGLE_W   = 9;
  localparam int unsigned LIMIT_W   = 9;
  localparam int unsigned FILL_W    = 7;
  localparam int unsigned ANGLE_MAX = (2 ** ANGLE_W) - 1;

  // held-angle count, 0..WINDOW_LENGTH
  localparam int unsigned N_W   = $clog2(WINDOW_LENGTH + 1);
  localparam int unsigned SUM_W = $clog2(WINDOW_LENGTH * ANGLE_MAX + 1);
  localparam int unsigned SQ_W  = $clog2(WINDOW_LENGTH * ANGLE_MAX * ANGLE_MAX + 1);
  localparam int unsigned ASQ_W = 2 * ANGLE_W;

  // deviation test operands
  localparam int unsigned NA_W   = N_W + ANGLE_W;
  localparam int unsigned LIMN_W = LIMIT_W + N_W;
  localparam int unsigned DEV_A  = (NA_W > SUM_W) ? NA_W : SUM_W;
  localparam int unsigned DEV_W  = (DEV_A > LIMN_W) ? DEV_A : LIMN_W;

  // spread test operands
  localparam int unsigned NN1_W  = 2 * N_W;
  localparam int unsigned LIM2_W = 2 * LIMIT_W;
  localparam int unsigned RHS_W  = LIM2_W + NN1_W;
  localparam int unsigned NSQ_W  = N_W + SQ_W;
  localparam int unsigned SSQ_W  = 2 * SUM_W;
  localparam int unsigned SP_A   = (NSQ_W > SSQ_W) ? NSQ_W : SSQ_W;
  localparam int unsigned SP_W   = (SP_A > RHS_W) ? SP_A : RHS_W;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN_LIMIT   = 1'b0,
    CFG_SPREAD_LIMIT = 1'b1
  } cfg_reg_e;

  // word leaving the window chain: new angle, dropped angle, their squares, full flag and fill count
  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [ASQ_W-1:0]   angle_sq;
    logic [ANGLE_W-1:0] old;
    logic [ASQ_W-1:0]   old_sq;
    logic               full;
    logic [N_W-1:0]     n;
  } win_item_t;

endpackage

### hw/rtl/swmd_cell.sv
// One window cell: holds a single angle and passes it to its neighbor on shift.
// Depends on swmd_pkg.
module swmd_cell (
  input  logic                           clk_i,
  input  logic                           shift_i,
  input  logic [swmd_pkg::ANGLE_W-1:0]   angle_i,
  output logic [swmd_pkg::ANGLE_W-1:0]   angle_o
);
  import swmd_pkg::*;

  logic [ANGLE_W-1:0] angle_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      angle_q <= angle_i;
    end
  end

  assign angle_o = angle_q;

endmodule

### hw/rtl/swmd_window.sv
// Angle window as a chain of cells plus fill count; emits new/dropped angle words.
// Depends on swmd_pkg and swmd_cell.
module swmd_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [swmd_pkg::ANGLE_W-1:0]  angle_i,
  output logic                          item_valid_o,
  input  logic                          item_take_i,
  output swmd_pkg::win_item_t           item_o
);
  import swmd_pkg::*;

  logic [ANGLE_W-1:0] cell_q [WINDOW_LENGTH];
  logic [N_W-1:0]     fill_q, fill_d;
  logic               valid_q;
  win_item_t          item_q, item_d;
  logic               en, accept, full;

  assign en         = !valid_q || item_take_i;
  assign accept     = in_valid_i && en;
  assign in_ready_o = en;
  assign full       = (fill_q == N_W'(WINDOW_LENGTH));

  // cell 0 holds the newest angle, the last cell the oldest once full
  for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      swmd_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(accept),
        .angle_i(angle_i),
        .angle_o(cell_q[i])
      );
    end else begin : g_body
      swmd_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(accept),
        .angle_i(cell_q[i-1]),
        .angle_o(cell_q[i])
      );
    end
  end

  always_comb begin
    fill_d = full ? fill_q : fill_q + N_W'(1);
    item_d.angle    = angle_i;
    item_d.angle_sq = ASQ_W'(angle_i) * ASQ_W'(angle_i);
    item_d.old      = cell_q[WINDOW_LENGTH-1];
    item_d.old_sq   = ASQ_W'(cell_q[WINDOW_LENGTH-1]) * ASQ_W'(cell_q[WINDOW_LENGTH-1]);
    item_d.full     = full;
    item_d.n        = fill_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q <= fill_d;
      end
      if (en) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### hw/rtl/swmd_stats.sv
// Running sums and the two cross-multiplied threshold tests, as a short pipeline.
// Depends on swmd_pkg.
module swmd_stats (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  output logic                          item_take_o,
  input  swmd_pkg::win_item_t           item_i,
  input  logic [swmd_pkg::LIMIT_W-1:0]  mean_limit_i,
  input  logic [swmd_pkg::LIM2_W-1:0]   spread_limit_sq_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic                          moving_o,
  output logic [swmd_pkg::N_W-1:0]      fill_o
);
  import swmd_pkg::*;

  // stage 2: running sums
  logic               v2_q;
  logic [SUM_W-1:0]   sum_q;
  logic [SQ_W-1:0]    sq_q;
  logic [ANGLE_W-1:0] a2_q;
  logic [N_W-1:0]     n2_q;
  logic [NN1_W-1:0]   nn1_q;
  // stage 3: products
  logic               v3_q;
  logic [NA_W-1:0]    na_q;
  logic [SUM_W-1:0]   sum3_q;
  logic [LIMN_W-1:0]  limn_q;
  logic [NSQ_W-1:0]   nsq_q;
  logic [SSQ_W-1:0]   ssq_q;
  logic [RHS_W-1:0]   rhs_q;
  logic [N_W-1:0]     n3_q;
  // stage 4: result
  logic               v4_q;
  logic               moving_q;
  logic [N_W-1:0]     n4_q;

  logic en2, en3, en4;
  logic [SUM_W-1:0] sum_d;
  logic [SQ_W-1:0]  sq_d;
  logic [DEV_W-1:0] na_x, sum_x, dev;
  logic [SP_W-1:0]  lhs;
  logic             moving_d;

  assign en4         = !v4_q || res_ready_i;
  assign en3         = !v3_q || en4;
  assign en2         = !v2_q || en3;
  assign item_take_o = en2;

  always_comb begin
    sum_d = sum_q + SUM_W'(item_i.angle);
    sq_d  = sq_q + SQ_W'(item_i.angle_sq);
    if (item_i.full) begin
      sum_d = sum_d - SUM_W'(item_i.old);
      sq_d  = sq_d - SQ_W'(item_i.old_sq);
    end
  end

  always_comb begin
    na_x  = DEV_W'(na_q);
    sum_x = DEV_W'(sum3_q);
    dev   = (na_x >= sum_x) ? (na_x - sum_x) : (sum_x - na_x);
    // n*sumsq >= sum^2 always holds for exact sums
    lhs   = SP_W'(nsq_q) - SP_W'(ssq_q);
    moving_d = (dev > DEV_W'(limn_q));
    if ((n3_q > N_W'(1)) && (lhs > SP_W'(rhs_q))) begin
      moving_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      sum_q <= '0;
      sq_q  <= '0;
    end else begin
      if (en2) begin
        v2_q <= item_valid_i;
        if (item_valid_i) begin
          sum_q <= sum_d;
          sq_q  <= sq_d;
        end
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && item_valid_i) begin
      a2_q  <= item_i.angle;
      n2_q  <= item_i.n;
      nn1_q <= NN1_W'(item_i.n) * NN1_W'(item_i.n - N_W'(1));
    end
    if (en3 && v2_q) begin
      na_q   <= NA_W'(n2_q) * NA_W'(a2_q);
      sum3_q <= sum_q;
      limn_q <= LIMN_W'(mean_limit_i) * LIMN_W'(n2_q);
      nsq_q  <= NSQ_W'(n2_q) * NSQ_W'(sq_q);
      ssq_q  <= SSQ_W'(sum_q) * SSQ_W'(sum_q);
      rhs_q  <= RHS_W'(spread_limit_sq_i) * RHS_W'(nn1_q);
      n3_q   <= n2_q;
    end
    if (en4 && v3_q) begin
      moving_q <= moving_d;
      n4_q     <= n3_q;
    end
  end

  assign res_valid_o = v4_q;
  assign moving_o    = moving_q;
  assign fill_o      = n4_q;

endmodule

### hw/rtl/sliding_window_motion_detector.sv
// Sliding window motion detector over heading angles (1..360 degrees).
//
// Input stream s_axis: one heading angle per word in tdata[8:0].
// Output stream m_axis: one word per input, tdata[0] = moving,
// tdata[7:1] = window fill (low 7 bits of the held-angle count).
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 = mean deviation limit, 1 = spread limit), both reset to 5.
// Write config only while no angle is in flight.
//
// An accepted angle passes the window item register, then the stats stages
// for sums, products and result, before output valid. One angle per cycle
// while m_axis tready holds. The window is a chain of cells that shifts once
// per accepted angle; the running sums update in one stage, so angles may arrive back to back.
// Each pipeline stage advances when it is empty or its successor advances,
// so a stalled output register still lets earlier stages fill up; s_axis
// tready drops only once all stages hold a word.
// Reset clears the fill count, sums and valid flags; the window contents
// need no clearing since a cell is only read after the window is full.
// Depends on swmd_pkg, swmd_window, swmd_cell and swmd_stats.
module sliding_window_motion_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // [8:0] heading_angle
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [0] moving, [7:1] window_fill
  input  logic                             cfg_we_i,
  input  logic [swmd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [swmd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import swmd_pkg::*;

  logic [LIMIT_W-1:0] mean_limit_q;
  logic [LIMIT_W-1:0] spread_limit_q;
  logic [LIM2_W-1:0]  spread_sq_q;

  logic                item_valid, item_take;
  win_item_t           item;
  logic                moving;
  logic [N_W-1:0]      fill;
  logic [N_W+FILL_W-1:0] fill_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_limit_q   <= LIMIT_RESET;
      spread_limit_q <= LIMIT_RESET;
      spread_sq_q    <= LIM2_W'(LIMIT_RESET) * LIM2_W'(LIMIT_RESET);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_MEAN_LIMIT:   mean_limit_q   <= LIMIT_W'(cfg_data_i);
          CFG_SPREAD_LIMIT: spread_limit_q <= LIMIT_W'(cfg_data_i);
          default: ;
        endcase
      end
      spread_sq_q <= LIM2_W'(spread_limit_q) * LIM2_W'(spread_limit_q);
    end
  end

  swmd_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .angle_i     (s_axis_tdata[ANGLE_W-1:0]),
    .item_valid_o(item_valid),
    .item_take_i (item_take),
    .item_o      (item)
  );

  swmd_stats u_stats (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_valid),
    .item_take_o      (item_take),
    .item_i           (item),
    .mean_limit_i     (mean_limit_q),
    .spread_limit_sq_i(spread_sq_q),
    .res_valid_o      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .moving_o         (moving),
    .fill_o           (fill)
  );

  assign fill_x       = (N_W + FILL_W)'(fill);
  assign m_axis_tdata = {fill_x[FILL_W-1:0], moving};

endmodule

### tb/swmd_checker.sv
// Scoreboard for the sliding window motion detector: keeps its own window,
// running sums and limits, predicts each output word and compares it.
// Depends on swmd_pkg.
module swmd_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [15:0]                     s_axis_tdata_i,   // [8:0] heading_angle
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  input  logic [7:0]                      m_axis_tdata_i,   // [0] moving, [7:1] window_fill
  input  logic                            cfg_we_i,
  input  logic [swmd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [swmd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     pending_o,
  output int unsigned                     errors_o,
  output int unsigned                     moving_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import swmd_pkg::*;

  typedef longint unsigned u64_t;

  // output word layout, moving in bit 0
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              moving;
  } motion_word_t;

  logic [ANGLE_W-1:0] held_angles [WINDOW_LENGTH];
  int unsigned        held_cnt    = 0;
  int unsigned        oldest_slot = 0;
  u64_t               angle_sum   = 0;
  u64_t               angle_sq_sum = 0;
  logic [LIMIT_W-1:0] mean_lim    = LIMIT_RESET;
  logic [LIMIT_W-1:0] spread_lim  = LIMIT_RESET;

  motion_word_t motion_q [$];
  int unsigned  err_cnt    = 0;
  int unsigned  moving_cnt = 0;

  // Push one angle into the window and work out the word it must produce.
  function automatic motion_word_t predict_motion(logic [ANGLE_W-1:0] angle);
    u64_t         a, old, n, na, dev, lim, lhs, rhs;
    motion_word_t w;
    a = angle;
    if (held_cnt >= WINDOW_LENGTH) begin
      old = held_angles[oldest_slot];
      angle_sum    -= old;
      angle_sq_sum -= old * old;
      held_angles[oldest_slot] = angle;
      oldest_slot = (oldest_slot + 1) % WINDOW_LENGTH;
    end else begin
      held_angles[held_cnt] = angle;
      held_cnt++;
    end
    angle_sum    += a;
    angle_sq_sum += a * a;

    n   = held_cnt;
    na  = n * a;
    dev = (na >= angle_sum) ? (na - angle_sum) : (angle_sum - na);
    lim = mean_lim;
    w.moving = (dev > lim * n);
    // a lone sample has no spread
    if (n > 1) begin
      lim = spread_lim;
      lhs = n * angle_sq_sum - angle_sum * angle_sum;
      rhs = lim * lim * n * (n - 1);
      if (lhs > rhs) w.moving = 1'b1;
    end
    w.fill = FILL_W'(n);
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    motion_word_t got, want;
    if (!rst_ni) begin
      held_cnt     = 0;
      oldest_slot  = 0;
      angle_sum    = 0;
      angle_sq_sum = 0;
      mean_lim     = LIMIT_RESET;
      spread_lim   = LIMIT_RESET;
      motion_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_MEAN_LIMIT:   mean_lim   = cfg_data_i[LIMIT_W-1:0];
          CFG_SPREAD_LIMIT: spread_lim = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        motion_q.insert(motion_q.size(), predict_motion(s_axis_tdata_i[ANGLE_W-1:0]));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = motion_word_t'(m_axis_tdata_i);
        if (got.moving) moving_cnt++;
        if (motion_q.size() == 0) begin
          $error("swmd_checker: output word 0x%02h with no angle outstanding",
                 m_axis_tdata_i);
          err_cnt++;
        end else begin
          want = motion_q.pop_front();
          if (got.moving !== want.moving) begin
            $error("swmd_checker: moving expected %0d got %0d", want.moving, got.moving);
            err_cnt++;
          end
          if (got.fill !== want.fill) begin
            $error("swmd_checker: window_fill expected %0d got %0d",
                   want.fill, got.fill);
            err_cnt++;
          end
        end
      end
      pending_o     <= motion_q.size();
      errors_o      <= err_cnt;
      moving_seen_o <= moving_cnt;
    end
  end

endmodule

### tb/tb_top.sv
// Top of the motion detector testbench: clock, reset, angle stimulus,
// limit writes, output back-pressure and the final verdict.
// Depends on swmd_pkg, sliding_window_motion_detector and swmd_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swmd_pkg::*;

  localparam int unsigned N_ITEMS       = 1550;
  localparam int unsigned MAX_GAP       = 8;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT    = 1000;

  typedef enum int {MODE_STEADY, MODE_STEP, MODE_OUTLIER, MODE_NOISE} angle_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [7:0]            m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_MEAN_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  int unsigned pending, errors, moving_seen;
  int unsigned tx_max_gap   = MAX_GAP;
  int unsigned rx_max_gap   = MAX_GAP;
  int unsigned rx_hold      = 0;
  int unsigned idle_cycles  = 0;
  int unsigned angles_sent  = 0;
  int unsigned settings_cnt = 0;

  // range ends, out-of-range angles and near-equal runs
  logic [ANGLE_W-1:0] corner_angles [16] = '{
    9'd1, 9'd1, 9'd2, 9'd360, 9'd0, 9'd511, 9'd361, 9'd180,
    9'd180, 9'd181, 9'd255, 9'd256, 9'd100, 9'd101, 9'd100, 9'd99
  };

  always #1 clk_i = ~clk_i;

  sliding_window_motion_detector u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  swmd_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pending_o       (pending),
    .errors_o        (errors),
    .moving_seen_o   (moving_seen)
  );

  // receiver: after each word, hold tready low for a random stall
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      rx_hold = $urandom_range(0, rx_max_gap);
    else if (rx_hold != 0)
      rx_hold--;
    m_axis_tready <= (rx_hold == 0);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_angle(input logic [ANGLE_W-1:0] angle);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 16'(angle);
    do @(posedge clk_i); while (!s_axis_tready);
    angles_sent++;
  endtask

  // stop sending and let every outstanding word come out
  task automatic settle_window();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [LIMIT_W-1:0] mean_lim, spread_lim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MEAN_LIMIT;
    cfg_data_i <= mean_lim;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SPREAD_LIMIT;
    cfg_data_i <= spread_lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_cnt++;
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LIMIT_W'(511);
      2:       return LIMIT_W'(360);
      3:       return LIMIT_W'($urandom_range(361, 511));
      default: return LIMIT_W'($urandom_range(0, 24));
    endcase
  endfunction

  function automatic int pick_centre();
    if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, ANGLE_MAX));
    return int'($urandom_range(1, 360));
  endfunction

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 2;
      default: return MAX_GAP;
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] next_angle(angle_mode_e mode, int centre,
                                                    int jitter);
    int v;
    if (mode == MODE_NOISE || (mode == MODE_OUTLIER && $urandom_range(0, 19) == 0))
      v = int'($urandom_range(0, ANGLE_MAX));
    else
      v = centre + int'($urandom_range(0, 2 * jitter)) - jitter;
    if (v < 0) v = 0;
    else if (v > int'(ANGLE_MAX)) v = int'(ANGLE_MAX);
    return ANGLE_W'(v);
  endfunction

  initial begin
    angle_mode_e mode;
    int          centre, jitter;
    int unsigned seg_len, pick;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits; first word is the lone-sample case
    foreach (corner_angles[i]) send_angle(corner_angles[i]);

    // widest limits: nothing can exceed them
    settle_window();
    write_limits(LIMIT_W'(511), LIMIT_W'(511));
    send_angle(9'd511);
    send_angle(9'd0);
    send_angle(9'd255);

    settle_window();
    write_limits('0, '0);
    repeat (3) send_angle(9'd180);

    while (angles_sent < N_ITEMS) begin
      settle_window();
      write_limits(pick_limit(), pick_limit());
      pick = $urandom_range(0, 9);
      if (pick < 4)      mode = MODE_STEADY;
      else if (pick < 7) mode = MODE_STEP;
      else if (pick < 9) mode = MODE_OUTLIER;
      else               mode = MODE_NOISE;
      centre     = pick_centre();
      jitter     = int'($urandom_range(0, 30));
      seg_len    = $urandom_range(60, 220);
      // last segment stops at the item budget
      if (seg_len > N_ITEMS - angles_sent) seg_len = N_ITEMS - angles_sent;
      tx_max_gap = pick_gap();
      rx_max_gap <= pick_gap();
      repeat (seg_len) begin
        if (mode == MODE_STEP && $urandom_range(0, 24) == 0) centre = pick_centre();
        if ($urandom_range(0, 199) == 0) settle_window();
        send_angle(next_angle(mode, centre, jitter));
      end
    end

    settle_window();
    $display("tb_top: %0d angles through the window under %0d limit settings, %0d moving",
             angles_sent, settings_cnt, moving_seen);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
